### hdl/netp_pkg.sv
// Shared types and constants of the NE entry table parser.
package netp_pkg;

   localparam logic [0:0] CSR_TABLE_LENGTH  = 1'b0;
   localparam logic [0:0] CSR_SEGMENT_COUNT = 1'b1;

   localparam logic [7:0] IND_SKIP    = 8'h00;
   localparam logic [7:0] IND_MOVABLE = 8'hFF;

   localparam logic [2:0] FIXED_SIZE    = 3'd3;
   localparam logic [2:0] MOVABLE_SIZE  = 3'd6;
   localparam logic [2:0] FIXED_OFF_LO  = 3'd1;
   localparam logic [2:0] MOVABLE_OFF_LO = 3'd4;
   localparam logic [2:0] MOVABLE_SEG   = 3'd3;

   // Reciprocal of three scaled by 2^17; exact for all 16-bit dividends.
   localparam logic [32:0] DIV3_RECIP = 33'h0AAAB;
   localparam int          DIV3_SHIFT = 17;

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      PH_COUNT     = 3'b001,
      PH_INDICATOR = 3'b010,
      PH_ENTRY     = 3'b100
   } phase_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] ordinal_number;
      logic [7:0]  segment_number;
      logic [15:0] entry_offset;
      logic        is_movable;
      logic        last;
   } result_type;

   typedef struct packed {
      logic       first_valid;
      logic       second_valid;
      result_type first;
      result_type second;
   } push_type;

endpackage

### hdl/netp_parser.sv
// Parse state, configuration registers and per-byte result generation.
module netp_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [0:0]        csr_index,
   input  logic [15:0]       csr_wdata,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              end_of_data,
   output netp_pkg::push_type push
);

   logic [15:0]          table_length_ff, table_length_in;
   logic [15:0]          segment_count_ff, segment_count_in;
   logic [15:0]          max_ord_ff, max_ord_in;
   netp_pkg::phase_type  phase_ff, phase_in;
   logic [2:0]           bie_ff, bie_in;
   logic [7:0]           left_ff, left_in;
   logic [7:0]           ind_ff, ind_in;
   logic [15:0]          ord_ff, ord_in;
   logic [16:0]          pos_ff, pos_in;
   logic [7:0]           hseg_ff, hseg_in;
   logic [15:0]          hoff_ff, hoff_in;
   logic                 finished_ff, finished_in;

   logic [32:0] prod;
   logic        movable;
   logic [2:0]  size;
   logic [2:0]  off_lo;
   logic [2:0]  bie_next;
   logic [7:0]  seg;
   logic [7:0]  left_next;
   logic        end_flag;
   logic        bundle_done;
   logic        entry_ok;
   logic        entry_done;
   logic [15:0] entry_off;

   assign prod = 33'(csr_wdata) * netp_pkg::DIV3_RECIP;

   always_comb begin
      table_length_in  = table_length_ff;
      segment_count_in = segment_count_ff;
      max_ord_in       = max_ord_ff;
      if (csr_we) begin
         if (csr_index == netp_pkg::CSR_TABLE_LENGTH) begin
            table_length_in = csr_wdata;
            max_ord_in      = prod[netp_pkg::DIV3_SHIFT +: 16] + 16'd1;
         end else begin
            segment_count_in = csr_wdata;
         end
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      bie_in      = bie_ff;
      left_in     = left_ff;
      ind_in      = ind_ff;
      ord_in      = ord_ff;
      pos_in      = pos_ff;
      hseg_in     = hseg_ff;
      hoff_in     = hoff_ff;
      finished_in = finished_ff;
      end_flag    = 1'b0;
      bundle_done = 1'b0;
      entry_ok    = 1'b0;
      entry_done  = 1'b0;
      movable     = (ind_ff == netp_pkg::IND_MOVABLE);
      size        = movable ? netp_pkg::MOVABLE_SIZE : netp_pkg::FIXED_SIZE;
      off_lo      = movable ? netp_pkg::MOVABLE_OFF_LO : netp_pkg::FIXED_OFF_LO;
      bie_next    = bie_ff + 3'd1;
      seg         = movable ? hseg_ff : ind_ff;
      left_next   = left_ff - 8'd1;
      entry_off   = {data_byte, hoff_ff[7:0]};

      if (accept && !finished_ff) begin
         case (phase_ff)
            netp_pkg::PH_COUNT: begin
               if (pos_ff >= {1'b0, table_length_ff} || data_byte == 8'd0) begin
                  end_flag = 1'b1;
               end else begin
                  left_in  = data_byte;
                  phase_in = netp_pkg::PH_INDICATOR;
               end
            end
            netp_pkg::PH_INDICATOR: begin
               ind_in = data_byte;
               if (data_byte == netp_pkg::IND_SKIP) begin
                  ord_in      = ord_ff + {8'd0, left_ff};
                  bundle_done = 1'b1;
               end else begin
                  ord_in   = ord_ff + 16'd1;
                  bie_in   = 3'd0;
                  phase_in = netp_pkg::PH_ENTRY;
               end
            end
            netp_pkg::PH_ENTRY: begin
               if (movable && bie_ff == netp_pkg::MOVABLE_SEG) begin
                  hseg_in = data_byte;
               end
               if (bie_ff == off_lo) begin
                  hoff_in = {8'd0, data_byte};
               end else if (bie_ff == off_lo + 3'd1) begin
                  hoff_in = entry_off;
               end
               bie_in = bie_next;
               if (bie_next >= size) begin
                  entry_done = 1'b1;
                  entry_ok = (ord_ff != 16'd0) && (ord_ff <= max_ord_ff) &&
                             (seg != 8'd0) && ({8'd0, seg} <= segment_count_ff);
                  bie_in  = 3'd0;
                  left_in = left_next;
                  if (left_next != 8'd0) begin
                     ord_in = ord_ff + 16'd1;
                  end else begin
                     bundle_done = 1'b1;
                  end
               end
            end
            default: begin
               phase_in = netp_pkg::PH_COUNT;
            end
         endcase

         if (!end_flag) begin
            pos_in = pos_ff + 17'd1;
         end
         if (bundle_done) begin
            phase_in = netp_pkg::PH_COUNT;
            if (pos_in >= {1'b0, table_length_ff}) begin
               end_flag = 1'b1;
            end
         end
         if (end_of_data) begin
            end_flag = 1'b1;
         end
         if (end_flag) begin
            finished_in = 1'b1;
         end
      end
   end

   always_comb begin
      push.first_valid  = 1'b0;
      push.second_valid = 1'b0;
      push.first        = '0;
      push.second       = '0;
      if (entry_done && entry_ok) begin
         push.first_valid          = 1'b1;
         push.first.kind           = 1'b0;
         push.first.ordinal_number = ord_ff;
         push.first.segment_number = seg;
         push.first.entry_offset   = entry_off;
         push.first.is_movable     = movable;
         push.first.last           = !end_flag;
         if (end_flag) begin
            push.second_valid          = 1'b1;
            push.second.kind           = 1'b1;
            push.second.ordinal_number = ord_in;
            push.second.last           = 1'b1;
         end
      end else if (end_flag) begin
         push.first_valid          = 1'b1;
         push.first.kind           = 1'b1;
         push.first.ordinal_number = ord_in;
         push.first.last           = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff  <= '0;
         segment_count_ff <= '0;
         max_ord_ff       <= 16'd1;
         phase_ff         <= netp_pkg::PH_COUNT;
         bie_ff           <= '0;
         left_ff          <= '0;
         ind_ff           <= '0;
         ord_ff           <= '0;
         pos_ff           <= '0;
         hseg_ff          <= '0;
         hoff_ff          <= '0;
         finished_ff      <= 1'b0;
      end else begin
         table_length_ff  <= table_length_in;
         segment_count_ff <= segment_count_in;
         max_ord_ff       <= max_ord_in;
         phase_ff         <= phase_in;
         bie_ff           <= bie_in;
         left_ff          <= left_in;
         ind_ff           <= ind_in;
         ord_ff           <= ord_in;
         pos_ff           <= pos_in;
         hseg_ff          <= hseg_in;
         hoff_ff          <= hoff_in;
         finished_ff      <= finished_in;
      end
   end

endmodule

### hdl/netp_out_queue.sv
// Small result queue that takes up to two results per cycle and delivers one per cycle while out_ready is high.
module netp_out_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  netp_pkg::push_type   push,
   output logic                 space,
   output logic                 out_valid,
   input  logic                 out_ready,
   output netp_pkg::result_type out_result
);

   localparam int AW = $clog2(netp_pkg::QUEUE_DEPTH);

   netp_pkg::result_type mem_ff [netp_pkg::QUEUE_DEPTH];
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [AW:0]   count_ff, count_in;
   logic          pop;
   logic [AW:0]   push_n;
   logic [AW-1:0] tail_next;

   assign out_valid  = (count_ff != '0);
   assign out_result = mem_ff[head_ff];
   assign pop        = out_valid && out_ready;
   assign space      = (count_ff <= (AW+1)'(netp_pkg::QUEUE_DEPTH - 2));
   assign tail_next  = tail_ff + AW'(1);
   assign push_n     = (AW+1)'(push.first_valid) + (AW+1)'(push.second_valid);

   always_comb begin
      head_in  = pop ? head_ff + AW'(1) : head_ff;
      tail_in  = tail_ff + push_n[AW-1:0];
      count_in = count_ff + push_n - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         mem_ff[tail_ff] <= push.first;
      end
      if (push.second_valid) begin
         mem_ff[tail_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

### hdl/ne_entry_table_parser.sv
// Top level of the NE entry table parser: byte stream in, entry and done words out.
//
// The req_ channel carries one entry table byte per word, starting at the first
// byte of the table; req_tlast marks the last byte of the data. The rsp_ channel
// carries one word per reported entry (rsp_tuser low) and one final done word
// (rsp_tuser high) with the total ordinal count; rsp_tlast marks the last word
// caused by an input byte. Table length and segment count must be written through
// the csr_ port while the block is idle; the block does not enforce this itself.
// Each byte is parsed in the cycle it is accepted, and its results are registered
// into the result queue and reach rsp_ behind any words already queued. One byte
// is accepted per cycle while req_tready is high; a byte can produce at most two
// words (entry and done), which is only possible on the final byte of a parse.
// A four-word result queue separates the two channels: req_tready stays high
// while at least two queue slots are free, so a stalled receiver only stops the
// input once fewer than two slots remain. After the done word, further bytes
// are accepted and dropped until reset. Reset clears the parse state, the queue
// and both configuration registers.
module ne_entry_table_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // end_of_data
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // ordinal_number, segment_number, entry_offset, is_movable
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast    // last
);

   netp_pkg::push_type   push;
   netp_pkg::result_type result;
   logic                 accept;

   assign accept = req_tvalid && req_tready;

   netp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .data_byte   (req_tdata),
      .end_of_data (req_tlast),
      .push        (push)
   );

   netp_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .space      (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {7'd0, result.is_movable, result.entry_offset,
                       result.segment_number, result.ordinal_number};
   assign rsp_tuser = result.kind;
   assign rsp_tlast = result.last;

endmodule
